// ===== design/lras_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lras_pkg;

  // Field widths of the pixel channel
  localparam int unsigned COORD_W = 10;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned LEN_W   = COORD_W + 1;
  localparam int unsigned ERR_W   = COORD_W + 3;

  // Input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Octant selection: bit 0 y-major, bit 1 y decreasing
  typedef enum logic [1:0] {
    CASE_XPOS = 2'd0,
    CASE_YPOS = 2'd1,
    CASE_XNEG = 2'd2,
    CASE_YNEG = 2'd3
  } case_sel_t;

  typedef logic [COORD_W-1:0]       coord_t;
  typedef logic [COLOR_W-1:0]       color_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic signed [ERR_W-1:0]  err_t;

endpackage

`default_nettype wire

// ===== design/line_rasterizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A pixel appears on the out_ channel in the cycle after its item is accepted.
// Throughput: one item per cycle while in_ready is high; the step update (error add,
// half-pixel compare, coordinate increment) sits between line state and result registers.
// in_ready stays high while the result register is empty or being drained.
// Reset (rst_n low, synchronous): no line active, result register empty.
module line_rasterizer
  import lras_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 200
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire logic   in_action,
  input  wire coord_t in_start_x,
  input  wire coord_t in_start_y,
  input  wire coord_t in_end_x,
  input  wire coord_t in_end_y,
  input  wire color_t in_color,
  output logic        out_valid,
  input  wire logic   out_ready,
  output coord_t      out_pixel_x,
  output coord_t      out_pixel_y,
  output color_t      out_pixel_color,
  output logic        out_write_enable,
  output logic        out_last
);

  // Line state
  coord_t    cur_x_r, cur_x_nxt;
  coord_t    cur_y_r, cur_y_nxt;
  err_t      err_acc_r, err_acc_nxt;
  len_t      minor_delta_r, minor_delta_nxt;
  len_t      major_len_r, major_len_nxt;
  len_t      remaining_r, remaining_nxt;
  case_sel_t case_sel_r, case_sel_nxt;
  color_t    line_color_r, line_color_nxt;
  logic      busy_r, busy_nxt;

  // Result register
  logic      out_valid_r, out_valid_nxt;
  coord_t    out_x_r, out_x_nxt;
  coord_t    out_y_r, out_y_nxt;
  color_t    out_color_r, out_color_nxt;
  logic      out_we_r, out_we_nxt;
  logic      out_last_r, out_last_nxt;

  logic      in_fire;
  logic      produce;

  // Start path
  logic      swap;
  coord_t    x0, y0, x1, y1;
  coord_t    dx, dm;
  logic      ydec;
  logic      xmaj;

  // Step path
  err_t      err_sum;
  err_t      major_ext;
  err_t      major_dbl;
  logic      first;
  logic      hit;
  coord_t    step_x, step_y;
  len_t      rem_dec;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign produce  = (in_action == ACT_START) || busy_r;

  // Order endpoints by x and classify the line
  always_comb begin
    swap = in_start_x > in_end_x;
    x0   = swap ? in_end_x   : in_start_x;
    y0   = swap ? in_end_y   : in_start_y;
    x1   = swap ? in_start_x : in_end_x;
    y1   = swap ? in_start_y : in_end_y;
    dx   = x1 - x0;
    ydec = y0 > y1;
    dm   = ydec ? (y0 - y1) : (y1 - y0);
    xmaj = dx >= dm;
  end

  // Advance the error term and pick the next pixel
  always_comb begin
    major_ext = err_t'({2'b00, major_len_r});
    major_dbl = err_t'({1'b0, major_len_r, 1'b0});
    err_sum   = err_acc_r + err_t'({1'b0, minor_delta_r, 1'b0});
    first     = remaining_r == major_len_r;
    if (case_sel_r == CASE_XNEG && first) begin
      hit = err_sum > major_ext;
    end else begin
      hit = err_sum >= major_ext;
    end
    step_x = cur_x_r;
    step_y = cur_y_r;
    case (case_sel_r)
      CASE_XPOS: begin
        step_x = cur_x_r + coord_t'(1);
        if (hit) step_y = cur_y_r + coord_t'(1);
      end
      CASE_XNEG: begin
        step_x = cur_x_r + coord_t'(1);
        if (hit) step_y = cur_y_r - coord_t'(1);
      end
      CASE_YPOS: begin
        step_y = cur_y_r + coord_t'(1);
        if (hit) step_x = cur_x_r + coord_t'(1);
      end
      CASE_YNEG: begin
        step_y = cur_y_r - coord_t'(1);
        if (hit) step_x = cur_x_r + coord_t'(1);
      end
      default: begin
        step_x = cur_x_r;
        step_y = cur_y_r;
      end
    endcase
    rem_dec = remaining_r - len_t'(1);
  end

  // Next line state and result
  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    err_acc_nxt     = err_acc_r;
    minor_delta_nxt = minor_delta_r;
    major_len_nxt   = major_len_r;
    remaining_nxt   = remaining_r;
    case_sel_nxt    = case_sel_r;
    line_color_nxt  = line_color_r;
    busy_nxt        = busy_r;
    out_x_nxt       = out_x_r;
    out_y_nxt       = out_y_r;
    out_color_nxt   = out_color_r;
    out_last_nxt    = out_last_r;

    if (in_fire && in_action == ACT_START) begin
      line_color_nxt = in_color;
      if (xmaj) begin
        major_len_nxt   = len_t'(dx);
        minor_delta_nxt = len_t'(dm);
        case_sel_nxt    = ydec ? CASE_XNEG : CASE_XPOS;
      end else begin
        major_len_nxt   = len_t'(dm);
        minor_delta_nxt = len_t'(dx);
        case_sel_nxt    = ydec ? CASE_YNEG : CASE_YPOS;
      end
      cur_x_nxt     = x0;
      cur_y_nxt     = y0;
      err_acc_nxt   = '0;
      remaining_nxt = major_len_nxt;
      busy_nxt      = major_len_nxt != '0;
      // Emit the start point as given, before ordering
      out_x_nxt     = in_start_x;
      out_y_nxt     = in_start_y;
      out_color_nxt = in_color;
      out_last_nxt  = major_len_nxt == '0;
    end else if (in_fire && busy_r) begin
      err_acc_nxt   = hit ? (err_sum - major_dbl) : err_sum;
      cur_x_nxt     = step_x;
      cur_y_nxt     = step_y;
      remaining_nxt = rem_dec;
      busy_nxt      = rem_dec != '0;
      out_x_nxt     = step_x;
      out_y_nxt     = step_y;
      out_color_nxt = line_color_r;
      out_last_nxt  = rem_dec == '0;
    end

    out_we_nxt = ({1'b0, out_x_nxt} < LEN_W'(SCREEN_WIDTH)) &&
                 ({1'b0, out_y_nxt} < LEN_W'(SCREEN_HEIGHT));
    if (!(in_fire && produce)) begin
      out_we_nxt = out_we_r;
    end

    // Load on a producing item, drop once taken
    if (in_fire) begin
      out_valid_nxt = produce;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_x_r       <= cur_x_nxt;
    cur_y_r       <= cur_y_nxt;
    err_acc_r     <= err_acc_nxt;
    minor_delta_r <= minor_delta_nxt;
    major_len_r   <= major_len_nxt;
    remaining_r   <= remaining_nxt;
    case_sel_r    <= case_sel_nxt;
    line_color_r  <= line_color_nxt;
    out_x_r       <= out_x_nxt;
    out_y_r       <= out_y_nxt;
    out_color_r   <= out_color_nxt;
    out_we_r      <= out_we_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = out_x_r;
  assign out_pixel_y      = out_y_r;
  assign out_pixel_color  = out_color_r;
  assign out_write_enable = out_we_r;
  assign out_last         = out_last_r;

  // A start item always yields a pixel
  a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action == ACT_START) |=> out_valid_r)
    else $error("start item gave no pixel");

  // A step with no active line yields nothing
  a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action == ACT_STEP && !busy_r) |=> !out_valid_r)
    else $error("step while idle gave a pixel");

  // The final step marks last and ends the line
  a_final_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action == ACT_STEP && busy_r && remaining_r == len_t'(1))
    |=> (out_valid_r && out_last_r && !busy_r))
    else $error("final pixel not marked last");

  // Pixels left stay within the major length while a line is active
  a_remaining_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (remaining_r != '0 && remaining_r <= major_len_r))
    else $error("remaining count out of range");

  // Error term stays within one half pixel either way
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (err_acc_r >= -major_ext && err_acc_r <= major_ext))
    else $error("error term out of range");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lras_pkg::*;

  localparam int unsigned SCR_W = 320;
  localparam int unsigned SCR_H = 200;
  localparam int unsigned ITEM_GOAL = 1650;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  logic   in_action;
  coord_t in_start_x;
  coord_t in_start_y;
  coord_t in_end_x;
  coord_t in_end_y;
  color_t in_color;
  logic   out_valid;
  logic   out_ready;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  color_t out_pixel_color;
  logic   out_write_enable;
  logic   out_last;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t col;
    logic   we;
    logic   fin;
  } pixel_t;

  // Walk each line the same way the block should and queue the pixels it must emit
  class pixel_scoreboard;
    pixel_t      pixel_q[$];
    int unsigned mismatches;
    coord_t      walk_x;
    coord_t      walk_y;
    int          err_acc;
    len_t        minor_len;
    len_t        major_len;
    len_t        left_cnt;
    case_sel_t   octant;
    color_t      pen;
    logic        active;

    function new();
      mismatches = 0;
      walk_x = '0;
      walk_y = '0;
      err_acc = 0;
      minor_len = '0;
      major_len = '0;
      left_cnt = '0;
      octant = CASE_XPOS;
      pen = '0;
      active = 1'b0;
    endfunction

    function pixel_t make_pixel(coord_t x, coord_t y, logic fin);
      pixel_t p;
      p.x = x;
      p.y = y;
      p.col = pen;
      p.we = (x < SCR_W) && (y < SCR_H);
      p.fin = fin;
      return p;
    endfunction

    function void note_item(logic act, coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                            color_t col);
      coord_t x0, y0, x1, y1;
      len_t   dx, dm;
      logic   ydec, first, hit;
      if (act == ACT_START) begin
        pen = col;
        // order endpoints so that x never decreases
        if (sx > ex) begin
          x0 = ex; y0 = ey; x1 = sx; y1 = sy;
        end else begin
          x0 = sx; y0 = sy; x1 = ex; y1 = ey;
        end
        dx = len_t'(x1) - len_t'(x0);
        ydec = y0 > y1;
        dm = ydec ? len_t'(y0) - len_t'(y1) : len_t'(y1) - len_t'(y0);
        if (dx >= dm) begin
          major_len = dx;
          minor_len = dm;
          octant = ydec ? CASE_XNEG : CASE_XPOS;
        end else begin
          major_len = dm;
          minor_len = dx;
          octant = ydec ? CASE_YNEG : CASE_YPOS;
        end
        walk_x = x0;
        walk_y = y0;
        err_acc = 0;
        left_cnt = major_len;
        active = major_len != '0;
        // the start pixel is the first endpoint as given, before ordering
        pixel_q.push_back(make_pixel(sx, sy, !active));
      end else if (active) begin
        first = left_cnt == major_len;
        err_acc += 2 * int'(minor_len);
        // a tie on the first step of a downward x-major line keeps y
        if (octant == CASE_XNEG && first) hit = err_acc > int'(major_len);
        else hit = err_acc >= int'(major_len);
        if (hit) err_acc -= 2 * int'(major_len);
        case (octant)
          CASE_XPOS: begin
            walk_x = walk_x + coord_t'(1);
            if (hit) walk_y = walk_y + coord_t'(1);
          end
          CASE_XNEG: begin
            walk_x = walk_x + coord_t'(1);
            if (hit) walk_y = walk_y - coord_t'(1);
          end
          CASE_YPOS: begin
            walk_y = walk_y + coord_t'(1);
            if (hit) walk_x = walk_x + coord_t'(1);
          end
          default: begin
            walk_y = walk_y - coord_t'(1);
            if (hit) walk_x = walk_x + coord_t'(1);
          end
        endcase
        left_cnt = left_cnt - len_t'(1);
        active = left_cnt != '0;
        pixel_q.push_back(make_pixel(walk_x, walk_y, !active));
      end
    endfunction

    function void check_pixel(coord_t x, coord_t y, color_t col, logic we, logic fin);
      pixel_t exp_px;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel: x=%0d y=%0d color=%06h we=%0b last=%0b",
                   x, y, col, we, fin);
        return;
      end
      exp_px = pixel_q.pop_front();
      if (exp_px.x !== x || exp_px.y !== y || exp_px.col !== col ||
          exp_px.we !== we || exp_px.fin !== fin) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("pixel mismatch: expected x=%0d y=%0d color=%06h we=%0b last=%0b, ",
                 exp_px.x, exp_px.y, exp_px.col, exp_px.we, exp_px.fin);
          $display("got x=%0d y=%0d color=%06h we=%0b last=%0b",
                   x, y, col, we, fin);
        end
      end
    endfunction

    function int unsigned pending();
      return pixel_q.size();
    endfunction
  endclass

  pixel_scoreboard sb;
  int unsigned     items_sent;
  int unsigned     cycles;
  int unsigned     stall_left;
  logic            no_idle;
  logic            random_phase;
  logic            press_hold;

  line_rasterizer #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_color        (in_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_write_enable(out_write_enable),
    .out_last        (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly no gap, sometimes a short one, rarely a long one
  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Nudge a coordinate by up to span in either direction, clamped to the field
  function coord_t near(coord_t c, int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return coord_t'(v);
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_item(logic act, coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                           color_t col);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x   <= ex;
    in_end_y   <= ey;
    in_color   <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Start a line, then request a number of pixels with junk in the unused fields
  task automatic draw_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey, color_t col,
                           int unsigned steps);
    send_item(ACT_START, sx, sy, ex, ey, col);
    repeat (steps)
      send_item(ACT_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), color_t'($urandom));
  endtask

  // Sample both handshakes at the edge: retire results before noting new items
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_pixel(out_pixel_x, out_pixel_y, out_pixel_color, out_write_enable, out_last);
    if (rst_n && in_valid && in_ready)
      sb.note_item(in_action, in_start_x, in_start_y, in_end_x, in_end_y, in_color);
    // drive the receiver's ready
    if (!rst_n || press_hold) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Hold off the receiver for a long stretch so the block backs up its input
  initial begin
    press_hold = 1'b0;
    @(posedge clk);
    while (!random_phase) @(posedge clk);
    repeat (150) @(posedge clk);
    press_hold <= 1'b1;
    repeat (300) @(posedge clk);
    press_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    coord_t      sx, sy, ex, ey;
    int          span;
    int unsigned major, steps, r, ddx, ddy;
    sb = new();
    items_sent = 0;
    cycles = 0;
    stall_left = 0;
    no_idle = 1'b0;
    random_phase = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_START;
    in_start_x <= '0;
    in_start_y <= '0;
    in_end_x <= '0;
    in_end_y <= '0;
    in_color <= '0;
    out_ready <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle step, single points at both corners, ties, abandon, off-screen
    send_item(ACT_STEP, '1, '1, '1, '1, '1);
    draw_line(10'd0, 10'd0, 10'd0, 10'd0, 24'h000000, 0);
    draw_line(10'd1023, 10'd1023, 10'd1023, 10'd1023, 24'hFFFFFF, 0);
    draw_line(10'd4, 10'd0, 10'd0, 10'd2, 24'h123456, 4);
    draw_line(10'd0, 10'd0, 10'd2, 10'd1, 24'hABCDEF, 2);
    draw_line(10'd10, 10'd10, 10'd11, 10'd13, 24'h00FF00, 1);
    draw_line(10'd0, 10'd1023, 10'd2, 10'd1020, 24'hFF0000, 3);
    draw_line(10'd318, 10'd198, 10'd322, 10'd195, 24'h0000FF, 5);

    // random lines, mostly short, some abandoned, some with idle steps past the end
    random_phase = 1'b1;
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 19) == 0) no_idle = ~no_idle;
      sx = coord_t'($urandom_range(0, 1023));
      sy = coord_t'($urandom_range(0, 1023));
      r = $urandom_range(0, 99);
      if (r < 80) span = 12;
      else if (r < 97) span = 64;
      else span = 1023;
      ex = near(sx, span);
      ey = near(sy, span);
      ddx = (ex > sx) ? 32'(ex - sx) : 32'(sx - ex);
      ddy = (ey > sy) ? 32'(ey - sy) : 32'(sy - ey);
      major = (ddx > ddy) ? ddx : ddy;
      r = $urandom_range(0, 99);
      if (r < 12) steps = $urandom_range(0, major);
      else if (r < 22) steps = major + $urandom_range(1, 3);
      else steps = major;
      // cut the final line short so the total stays at the goal
      if (items_sent + 1 + steps > ITEM_GOAL) steps = ITEM_GOAL - items_sent - 1;
      draw_line(sx, sy, ex, ey, color_t'($urandom), steps);
    end
    in_valid <= 1'b0;

    // drain, then keep watching for stray pixels before the verdict
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d pixels never seen", sb.mismatches, sb.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/lras_pkg.sv
design/line_rasterizer.sv
verif/testbench.sv
